// File: rtl/ipmd_pkg.sv
// ipmd_pkg: types, constants and microcode table of the incremental PID duty block.
// No dependencies; used by every rtl module.
package ipmd_pkg;

  localparam int unsigned PcW = 3;
  localparam logic [PcW-1:0] LastStep = 3'd5;

  localparam int unsigned ErrW  = 26;
  localparam int unsigned DiffW = 28;
  localparam int unsigned GainW = 16;
  localparam int unsigned ProdW = DiffW + GainW;
  localparam int unsigned AccW  = 46;
  localparam int unsigned IncW  = AccW - 8;
  localparam int unsigned SumW  = 48;
  localparam int unsigned PW    = SumW + 6;
  localparam int unsigned DutyW = 11;

  localparam logic [DutyW-1:0] DutyNeutral = 11'd1000;
  localparam logic [DutyW-1:0] DutyHigh    = 11'd2000;
  localparam logic [DutyW-1:0] DutyLow     = 11'd10;
  localparam logic signed [PW-1:0] PMax    = 54'sd256000;

  localparam logic signed [GainW-1:0] KpReset = 16'sd1280;
  localparam logic signed [GainW-1:0] KiReset = 16'sd0;
  localparam logic signed [GainW-1:0] KdReset = 16'sd2560;

  typedef enum logic [1:0] {
    REG_KP = 2'd0,
    REG_KI = 2'd1,
    REG_KD = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    GSEL_P = 2'd0,
    GSEL_I = 2'd1,
    GSEL_D = 2'd2
  } gsel_e;

  typedef enum logic [1:0] {
    COND_NEVER    = 2'd0,
    COND_ALWAYS   = 2'd1,
    COND_NO_IN    = 2'd2,
    COND_OUT_BUSY = 2'd3
  } cond_e;

  typedef struct packed {
    logic           accept;
    logic           mac;
    gsel_e          gsel;
    logic           sum_upd;
    logic           out_wr;
    cond_e          cond;
    logic [PcW-1:0] jmp;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
  } dp_status_t;

  function automatic ucode_t ucode_rom(logic [PcW-1:0] pc);
    ucode_t w;
    w = '{accept: 1'b0, mac: 1'b0, gsel: GSEL_P, sum_upd: 1'b0, out_wr: 1'b0,
          cond: COND_NEVER, jmp: '0};
    case (pc)
      3'd0: begin
        w.accept = 1'b1;
        w.cond   = COND_NO_IN;
        w.jmp    = 3'd0;
      end
      3'd1: begin
        w.mac  = 1'b1;
        w.gsel = GSEL_P;
      end
      3'd2: begin
        w.mac  = 1'b1;
        w.gsel = GSEL_I;
      end
      3'd3: begin
        w.mac  = 1'b1;
        w.gsel = GSEL_D;
      end
      3'd4: begin
        w.sum_upd = 1'b1;
      end
      3'd5: begin
        w.out_wr = 1'b1;
        w.cond   = COND_OUT_BUSY;
        w.jmp    = 3'd5;
      end
      default: begin
        w.cond = COND_ALWAYS;
        w.jmp  = 3'd0;
      end
    endcase
    return w;
  endfunction

endpackage

// File: rtl/ipmd_if.sv
// ipmd_if: valid/ready channel interfaces for samples, duty results and gain writes.
// No dependencies; field widths are written out as literals.
interface ipmd_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] target_speed;
  logic signed [15:0] measured_speed;
  modport source (output valid, output target_speed, output measured_speed, input ready);
  modport sink   (input valid, input target_speed, input measured_speed, output ready);
endinterface

interface ipmd_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] pwm_duty;
  modport source (output valid, output pwm_duty, input ready);
  modport sink   (input valid, input pwm_duty, output ready);
endinterface

interface ipmd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/incremental_pid_motor_duty_top.sv
// The result beat is registered after the three MAC steps, the sum update and the output
// write of the six-step microprogram that runs the three gain products through one shared
// multiply-accumulate unit; a new sample is accepted only once the last result is written.
// Reset: async active low; gains return to 5.0/0/10.0, error history and sum clear.
// Depends on ipmd_pkg, ipmd_if, ipmd_seq and ipmd_datapath.
module incremental_pid_motor_duty_top import ipmd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ipmd_cfg_if.sink   cfg_i,
  ipmd_in_if.sink    in_i,
  ipmd_out_if.source out_o
);

  ucode_t     ctl;
  dp_status_t status;

  ipmd_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctl_o    (ctl)
  );

  ipmd_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .status_o (status),
    .cfg_s    (cfg_i),
    .in_s     (in_i),
    .out_s    (out_o)
  );

endmodule

// File: rtl/ipmd_seq.sv
// ipmd_seq: step counter and microcode table with conditional jumps.
// Depends on ipmd_pkg.
module ipmd_seq import ipmd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_status_t status_i,
  output ucode_t     ctl_o
);

  logic [PcW-1:0] pc_q, pc_d;
  ucode_t         w;
  logic           take;

  assign w     = ucode_rom(pc_q);
  assign ctl_o = w;

  always_comb begin
    case (w.cond)
      COND_NEVER:    take = 1'b0;
      COND_ALWAYS:   take = 1'b1;
      COND_NO_IN:    take = !status_i.in_valid;
      COND_OUT_BUSY: take = status_i.out_busy;
      default:       take = 1'b0;
    endcase
  end

  always_comb begin
    if (take) begin
      pc_d = w.jmp;
    end else if (pc_q == LastStep) begin
      pc_d = '0;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// File: rtl/ipmd_datapath.sv
// ipmd_datapath: gain registers, error history, shared MAC, saturating sum, duty map.
// Depends on ipmd_pkg and the ipmd interfaces.
module ipmd_datapath import ipmd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ucode_t     ctl_i,
  output dp_status_t status_o,
  ipmd_cfg_if.sink   cfg_s,
  ipmd_in_if.sink    in_s,
  ipmd_out_if.source out_s
);

  logic signed [GainW-1:0] kp_q, ki_q, kd_q;
  logic signed [ErrW-1:0]  e_q, e1_q, e2_q, e_in;
  logic signed [AccW-1:0]  acc_q;
  logic signed [SumW-1:0]  sum_q;
  logic                    ov_q;
  logic [DutyW-1:0]        duty_q, duty_d;

  logic signed [DiffW-1:0] diff;
  logic signed [GainW-1:0] gain;
  logic signed [ProdW-1:0] prod;
  logic signed [AccW-1:0]  acc_rnd;
  logic signed [IncW-1:0]  inc8;
  logic signed [SumW:0]    sum_wide;
  logic signed [SumW-1:0]  sum_d;
  logic signed [PW-1:0]    p, negp;
  logic [PW-9:0]           magq;
  logic [DutyW-1:0]        duty_pos;

  logic accept, out_busy;

  assign cfg_s.ready = 1'b1;
  assign in_s.ready  = ctl_i.accept;
  assign accept      = in_s.valid && ctl_i.accept;
  assign out_busy    = ov_q && !out_s.ready;
  assign status_o    = '{in_valid: in_s.valid, out_busy: out_busy};

  assign out_s.valid    = ov_q;
  assign out_s.pwm_duty = duty_q;

  assign e_in = {{2{in_s.target_speed[23]}}, in_s.target_speed}
              - {{2{in_s.measured_speed[15]}}, in_s.measured_speed, 8'b0};

  always_comb begin
    case (ctl_i.gsel)
      GSEL_P: begin
        gain = kp_q;
        diff = DiffW'(e_q) - DiffW'(e1_q);
      end
      GSEL_I: begin
        gain = ki_q;
        diff = DiffW'(e_q);
      end
      GSEL_D: begin
        gain = kd_q;
        diff = DiffW'(e_q) - (DiffW'(e1_q) <<< 1) + DiffW'(e2_q);
      end
      default: begin
        gain = '0;
        diff = '0;
      end
    endcase
  end

  assign prod = ProdW'(gain) * ProdW'(diff);

  // truncate Q.16 toward zero into Q.8
  assign acc_rnd  = acc_q + (acc_q[AccW-1] ? AccW'(255) : AccW'(0));
  assign inc8     = IncW'(acc_rnd >>> 8);
  assign sum_wide = (SumW+1)'(sum_q) + (SumW+1)'(inc8);

  always_comb begin
    if (sum_wide[SumW] != sum_wide[SumW-1]) begin
      sum_d = sum_wide[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      sum_d = sum_wide[SumW-1:0];
    end
  end

  // product = sum * 20
  assign p    = (PW'(sum_q) <<< 4) + (PW'(sum_q) <<< 2);
  assign negp = -p;
  assign magq = negp[PW-1:8];
  assign duty_pos = DutyNeutral - {1'b0, p[17:8]};

  always_comb begin
    if (p > PMax) begin
      duty_d = DutyLow;
    end else if (!p[PW-1]) begin
      duty_d = (duty_pos < DutyLow) ? DutyLow : duty_pos;
    end else if (magq >= (PW-8)'(DutyNeutral)) begin
      duty_d = DutyHigh;
    end else begin
      duty_d = DutyNeutral + {1'b0, magq[9:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q <= KpReset;
      ki_q <= KiReset;
      kd_q <= KdReset;
    end else if (cfg_s.valid) begin
      case (cfg_s.index)
        REG_KP:  kp_q <= cfg_s.data;
        REG_KI:  ki_q <= cfg_s.data;
        REG_KD:  kd_q <= cfg_s.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_q  <= '0;
      e2_q  <= '0;
      sum_q <= '0;
    end else if (ctl_i.sum_upd) begin
      e1_q  <= e_q;
      e2_q  <= e1_q;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (ctl_i.out_wr && !out_busy) begin
      ov_q <= 1'b1;
    end else if (out_s.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      e_q   <= e_in;
      acc_q <= '0;
    end else if (ctl_i.mac) begin
      acc_q <= acc_q + AccW'(prod);
    end
    if (ctl_i.out_wr && !out_busy) begin
      duty_q <= duty_d;
    end
  end

endmodule

// File: test/testbench.sv
// testbench: drives sample beats, gain writes and duty-ready stalls into the PID duty block
// and checks every duty beat against an in-bench velocity-form PID predictor.
// Depends on ipmd_pkg, the ipmd_*_if interfaces and incremental_pid_motor_duty_top.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ipmd_pkg::*;

  localparam longint SumMax     = 64'sh7FFF_FFFF_FFFF;
  localparam longint SumMin     = -SumMax - 1;
  localparam longint DutyScale  = 20;
  localparam longint DutyMid    = 1000;
  localparam longint DutyOver   = 999;
  localparam longint DutyTop    = 2000;
  localparam longint DutyBottom = 10;
  localparam longint TargetMax  = 8388607;
  localparam longint TargetMin  = -8388608;
  localparam longint ErrMax     = 16777215;
  localparam longint ErrMin     = -16776960;
  localparam logic [1:0] RegUnused = 2'd3;

  logic clk;
  logic rst_n;

  ipmd_cfg_if cfg_if();
  ipmd_in_if  in_if();
  ipmd_out_if out_if();

  incremental_pid_motor_duty_top u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // predictor state
  logic signed [15:0] gain_p, gain_i, gain_d;
  logic signed [25:0] err_prev, err_older;
  logic signed [47:0] duty_sum;
  logic [10:0]        duty_q[$];

  int n_errors;
  int gap_pct;
  int stall_pct;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic logic [10:0] pid_duty_step(logic signed [23:0] target,
                                                logic signed [15:0] measured);
    longint err, incr, acc, prod, mag, duty;
    err  = longint'(target) - longint'(measured) * 256;
    incr = longint'(gain_p) * (err - longint'(err_prev))
         + longint'(gain_i) * err
         + longint'(gain_d) * (err - 2 * longint'(err_prev) + longint'(err_older));
    acc  = longint'(duty_sum) + incr / 256;
    if (acc > SumMax) acc = SumMax;
    if (acc < SumMin) acc = SumMin;
    duty_sum  = acc[47:0];
    err_older = err_prev;
    err_prev  = err[25:0];
    prod = acc * DutyScale;
    if (prod > DutyMid * 256) begin
      duty = DutyMid - DutyOver;
    end else if (prod >= 0) begin
      duty = DutyMid - prod / 256;
    end else begin
      mag  = -prod / 256;
      duty = (mag >= DutyTop - DutyMid) ? DutyTop : DutyMid + mag;
    end
    if (duty > DutyTop) duty = DutyTop;
    if (duty < DutyBottom) duty = DutyBottom;
    return duty[10:0];
  endfunction

  // zero unless the pct percent chance hits; then short, now and then long
  function automatic int pick_idle(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(7) == 0) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  // log-spread error magnitude; with an integral gain the sign leans against the sum
  function automatic longint rand_error();
    int unsigned shift;
    longint err;
    shift = ($urandom_range(7) == 0) ? $urandom_range(25) : $urandom_range(14);
    err = longint'($urandom_range((32'd1 << shift) - 1));
    if (gain_i != 0 && (duty_sum > 48'sd12800 || duty_sum < -48'sd12800) &&
        $urandom_range(3) != 0) begin
      if ((duty_sum > 0) == (gain_i > 0)) err = -err;
    end else if ($urandom_range(1) == 1) begin
      err = -err;
    end
    return err;
  endfunction

  task automatic send_sample(input logic signed [23:0] target,
                             input logic signed [15:0] measured);
    int gap;
    gap = pick_idle(gap_pct);
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid          = 1'b1;
    in_if.target_speed   = target;
    in_if.measured_speed = measured;
    do @(posedge clk); while (!in_if.ready);
    duty_q.push_back(pid_duty_step(target, measured));
  endtask

  // picks a random measured speed that keeps target = measured*256 + err in range
  task automatic send_error(input longint err_in);
    longint err, lo, hi, m;
    err = err_in;
    if (err > ErrMax) err = ErrMax;
    if (err < ErrMin) err = ErrMin;
    hi = (TargetMax - err) >>> 8;
    lo = -((err - TargetMin) >>> 8);
    if (hi > 32767) hi = 32767;
    if (lo < -32768) lo = -32768;
    m = lo + longint'($urandom_range(int'(hi - lo)));
    send_sample(24'(m * 256 + err), 16'(m));
  endtask

  task automatic write_gain(input logic [1:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = value;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_KP: gain_p = value;
      REG_KI: gain_i = value;
      REG_KD: gain_d = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (duty_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_reset_gains();
    gap_pct   = 20;
    stall_pct = 20;
    send_sample(24'sh000000, 16'sh0000);
    send_sample(24'sh7FFFFF, 16'sh8000);
    send_sample(24'sh800000, 16'sh7FFF);
    send_sample(24'sh7FFFFF, 16'sh7FFF);
    send_sample(24'sh800000, 16'sh8000);
    send_error(640);
    send_error(-2000);
    send_error(0);
    send_error(0);
    wait_drained();
  endtask

  // Ki = 1.0 alone adds each error to the sum, so the sum is stepped onto each entry
  task automatic test_duty_edges();
    longint sums [16] = '{0, 1, -1, 13, -13, 12659, -12787, 12672, 12799, 12800, 12801,
                          -12799, -12800, -12801, 3000000, -3000000};
    write_gain(REG_KP, 16'h0000);
    write_gain(REG_KI, 16'h0100);
    write_gain(REG_KD, 16'h0000);
    gap_pct   = 50;
    stall_pct = 50;
    foreach (sums[k]) begin
      do send_error(sums[k] - longint'(duty_sum));
      while (longint'(duty_sum) != sums[k]);
    end
    wait_drained();
  endtask

  task automatic test_random_gains();
    logic [15:0] kp_tab [6] = '{16'h0500, 16'h0100, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000};
    logic [15:0] ki_tab [6] = '{16'h0010, 16'h0000, 16'h0000, 16'h0001, 16'h8000, 16'h7FFF};
    logic [15:0] kd_tab [6] = '{16'h0A00, 16'h0000, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000};
    int gap_tab   [8] = '{30, 0, 60, 15, 0, 30, 45, 10};
    int stall_tab [8] = '{30, 0, 15, 60, 30, 0, 45, 10};
    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 6) begin
        write_gain(REG_KP, kp_tab[ph]);
        write_gain(REG_KI, ki_tab[ph]);
        write_gain(REG_KD, kd_tab[ph]);
      end else if (ph == 6) begin
        write_gain(REG_KP, 16'($urandom_range(4095) - 2048));
        write_gain(REG_KI, 16'($urandom_range(255) - 128));
        write_gain(REG_KD, 16'($urandom_range(4095) - 2048));
      end else begin
        write_gain(REG_KP, 16'($urandom));
        write_gain(REG_KI, 16'($urandom));
        write_gain(REG_KD, 16'($urandom));
      end
      gap_pct   = gap_tab[ph];
      stall_pct = stall_tab[ph];
      for (int n = 0; n < 130; n++) begin
        if (n == 40 || $urandom_range(63) == 0) wait_drained();
        if ($urandom_range(15) == 0) begin
          send_sample(24'($urandom), 16'($urandom));
        end else begin
          send_error(rand_error());
        end
      end
      wait_drained();
    end
  endtask

  task automatic test_ignored_index();
    write_gain(REG_KP, 16'h0300);
    write_gain(REG_KI, 16'h0008);
    write_gain(REG_KD, 16'h0400);
    write_gain(RegUnused, 16'hFFFF);
    gap_pct   = 25;
    stall_pct = 25;
    repeat (10) send_error(rand_error());
    wait_drained();
    write_gain(RegUnused, 16'h0000);
    repeat (10) send_error(rand_error());
    wait_drained();
  endtask

  // full-scale error against the most negative integral gain drives the sum far negative
  task automatic test_large_sum();
    write_gain(REG_KP, 16'h0000);
    write_gain(REG_KD, 16'h0000);
    write_gain(REG_KI, 16'h8000);
    gap_pct   = 0;
    stall_pct = 0;
    repeat (24) send_sample(24'sh7FFFFF, 16'sh8000);
    stall_pct = 30;
    repeat (3) send_sample(24'sh800000, 16'sh7FFF);
    wait_drained();
  endtask

  initial begin
    logic [10:0] want;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        if (duty_q.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected pwm_duty beat, expected none, actual %0d",
                   $time, out_if.pwm_duty);
        end else begin
          want = duty_q.pop_front();
          if (out_if.pwm_duty !== want) begin
            n_errors++;
            $display("%0t: pwm_duty mismatch, expected %0d, actual %0d",
                     $time, want, out_if.pwm_duty);
          end
        end
      end
    end
  end

  initial begin
    int hold;
    hold = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0) hold = pick_idle(stall_pct);
      if (hold > 0) begin
        out_if.ready = 1'b0;
        hold--;
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  initial begin
    #8_000_000;
    $display("testbench: errors");
    $finish;
  end

  initial begin
    rst_n                = 1'b0;
    in_if.valid          = 1'b0;
    in_if.target_speed   = '0;
    in_if.measured_speed = '0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = '0;
    cfg_if.data          = '0;
    n_errors             = 0;
    gap_pct              = 0;
    stall_pct            = 0;
    gain_p               = 16'sd1280;
    gain_i               = 16'sd0;
    gain_d               = 16'sd2560;
    err_prev             = '0;
    err_older            = '0;
    duty_sum             = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_gains();
    test_duty_edges();
    test_random_gains();
    test_ignored_index();
    test_large_sum();

    if (n_errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
